>>> hdl/blsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blsc_pkg
// Types, codes and reset values shared by the button/LED session controller.
// ----------------------------------------------------------------------------
package blsc_pkg;

    localparam int unsigned OP_W     = 3;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned PAT_W    = 3;
    localparam int unsigned DUR_W    = 16;
    localparam int unsigned TMO_W    = 20;
    localparam int unsigned CIDX_W   = 3;
    localparam int unsigned CDATA_W  = 20;
    localparam int unsigned S_DATA_W = 40;
    localparam int unsigned M_DATA_W = 16;

    localparam logic [DUR_W-1:0] SHORT_PRESS_RST    = 16'd150;
    localparam logic [DUR_W-1:0] PRESS_GAP_RST      = 16'd250;
    localparam logic [DUR_W-1:0] BOOT_PRESS_RST     = 16'd2500;
    localparam logic [DUR_W-1:0] AFTER_POWER_ON_RST = 16'd1000;
    localparam logic [DUR_W-1:0] LONG_PRESS_RST     = 16'd2500;
    localparam logic [DUR_W-1:0] AFTER_POWER_OFF_RST = 16'd1000;
    localparam logic [TMO_W-1:0] CONFIRM_TIMEOUT_RST = 20'd15000;

    typedef enum logic [OP_W-1:0] {
        OP_LED_SEEN  = 3'd0,
        OP_POLL      = 3'd1,
        OP_POWER_ON  = 3'd2,
        OP_START_REC = 3'd3,
        OP_STOP_REC  = 3'd4,
        OP_POWER_OFF = 3'd5
    } opcode_t;

    typedef enum logic [PAT_W-1:0] {
        LED_UNKNOWN  = 3'd0,
        LED_OFF      = 3'd1,
        LED_SOLID    = 3'd2,
        LED_SLOW     = 3'd3,
        LED_FAST     = 3'd4,
        LED_ABNORMAL = 3'd5
    } led_t;

    typedef enum logic [2:0] {
        TK_NONE    = 3'd0,
        TK_BOOT    = 3'd1,
        TK_AUTOREC = 3'd2,
        TK_START   = 3'd3,
        TK_STOP    = 3'd4
    } task_t;

    typedef enum logic [2:0] {
        E_NONE       = 3'd0,
        E_CARD       = 3'd1,
        E_ABNORMAL   = 3'd2,
        E_BOOT_TO    = 3'd3,
        E_UNEXPECTED = 3'd4
    } err_t;

    typedef enum logic [1:0] {
        PR_NONE  = 2'd0,
        PR_SHORT = 2'd1,
        PR_LONG  = 2'd2
    } press_t;

    typedef enum logic [CIDX_W-1:0] {
        REG_SHORT_PRESS     = 3'd0,
        REG_PRESS_GAP       = 3'd1,
        REG_BOOT_PRESS      = 3'd2,
        REG_AFTER_POWER_ON  = 3'd3,
        REG_LONG_PRESS      = 3'd4,
        REG_AFTER_POWER_OFF = 3'd5,
        REG_CONFIRM_TIMEOUT = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [DUR_W-1:0] short_press_ms;
        logic [DUR_W-1:0] press_gap_ms;
        logic [DUR_W-1:0] boot_press_ms;
        logic [DUR_W-1:0] after_power_on_ms;
        logic [DUR_W-1:0] long_press_ms;
        logic [DUR_W-1:0] after_power_off_ms;
        logic [TMO_W-1:0] confirm_timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [TIME_W-1:0] now_ms;
        logic [PAT_W-1:0]  led_pattern;
        logic              auto_record;
    } item_t;

    typedef struct packed {
        logic             reply;
        press_t           press_action;
        err_t             last_error;
        logic             busy_res;
        logic [PAT_W-1:0] current_pattern;
        logic             is_recording;
        logic             is_idle;
        logic             is_off;
    } status_t;

endpackage

>>> hdl/blsc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blsc_cfg_regs
// Timing registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module blsc_cfg_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [blsc_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [blsc_pkg::CDATA_W-1:0] cfg_data,
    output blsc_pkg::cfg_t               cfg
);
    import blsc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_SHORT_PRESS:     cfg_next.short_press_ms     = cfg_data[DUR_W-1:0];
                REG_PRESS_GAP:       cfg_next.press_gap_ms       = cfg_data[DUR_W-1:0];
                REG_BOOT_PRESS:      cfg_next.boot_press_ms      = cfg_data[DUR_W-1:0];
                REG_AFTER_POWER_ON:  cfg_next.after_power_on_ms  = cfg_data[DUR_W-1:0];
                REG_LONG_PRESS:      cfg_next.long_press_ms      = cfg_data[DUR_W-1:0];
                REG_AFTER_POWER_OFF: cfg_next.after_power_off_ms = cfg_data[DUR_W-1:0];
                REG_CONFIRM_TIMEOUT: cfg_next.confirm_timeout_ms = cfg_data[TMO_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_press_ms     <= SHORT_PRESS_RST;
            cfg_reg.press_gap_ms       <= PRESS_GAP_RST;
            cfg_reg.boot_press_ms      <= BOOT_PRESS_RST;
            cfg_reg.after_power_on_ms  <= AFTER_POWER_ON_RST;
            cfg_reg.long_press_ms      <= LONG_PRESS_RST;
            cfg_reg.after_power_off_ms <= AFTER_POWER_OFF_RST;
            cfg_reg.confirm_timeout_ms <= CONFIRM_TIMEOUT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hdl/blsc_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blsc_engine
// Session state and the combinational event update that produces one result.
// ----------------------------------------------------------------------------
module blsc_engine (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  blsc_pkg::item_t item,
    input  blsc_pkg::cfg_t  cfg,
    output blsc_pkg::status_t result
);
    import blsc_pkg::*;

    logic [PAT_W-1:0]  seen_reg, seen_next;
    task_t             task_reg, task_next;
    logic [TIME_W-1:0] deadline_reg, deadline_next;
    logic              guard_reg, guard_next;
    logic [TIME_W-1:0] release_reg, release_next;
    err_t              err_reg, err_next;
    logic              intent_reg, intent_next;

    logic              reply;
    press_t            press;
    logic              guard_open;
    logic              deadline_hit;
    logic [DUR_W:0]    short_hold;
    logic [DUR_W:0]    boot_hold;
    logic [DUR_W:0]    off_hold;
    logic [TIME_W-1:0] short_release;
    logic [TIME_W-1:0] boot_release;
    logic [TIME_W-1:0] off_release;
    logic [TIME_W-1:0] new_deadline;

    always_comb begin
        short_hold    = {1'b0, cfg.short_press_ms} + {1'b0, cfg.press_gap_ms};
        boot_hold     = {1'b0, cfg.boot_press_ms} + {1'b0, cfg.after_power_on_ms};
        off_hold      = {1'b0, cfg.long_press_ms} + {1'b0, cfg.after_power_off_ms};
        short_release = item.now_ms + TIME_W'(short_hold);
        boot_release  = item.now_ms + TIME_W'(boot_hold);
        off_release   = item.now_ms + TIME_W'(off_hold);
        new_deadline  = item.now_ms + TIME_W'(cfg.confirm_timeout_ms);
        guard_open    = !guard_reg || (item.now_ms >= release_reg);
        deadline_hit  = item.now_ms >= deadline_reg;
    end

    always_comb begin
        seen_next     = seen_reg;
        task_next     = task_reg;
        deadline_next = deadline_reg;
        guard_next    = guard_reg;
        release_next  = release_reg;
        err_next      = err_reg;
        intent_next   = intent_reg;
        reply         = 1'b0;
        press         = PR_NONE;

        case (item.opcode)
            OP_LED_SEEN: begin
                seen_next = item.led_pattern;
                if (item.led_pattern == LED_FAST) begin
                    task_next     = TK_NONE;
                    deadline_next = '0;
                    err_next      = E_CARD;
                end else if (item.led_pattern == LED_ABNORMAL) begin
                    task_next     = TK_NONE;
                    deadline_next = '0;
                    err_next      = E_ABNORMAL;
                end else if ((task_reg == TK_BOOT &&
                              (item.led_pattern == LED_SOLID || item.led_pattern == LED_SLOW)) ||
                             ((task_reg == TK_AUTOREC || task_reg == TK_START) &&
                              item.led_pattern == LED_SLOW) ||
                             (task_reg == TK_STOP && item.led_pattern == LED_SOLID)) begin
                    task_next     = TK_NONE;
                    deadline_next = '0;
                    err_next      = E_NONE;
                end
            end
            OP_POLL: begin
                if (guard_reg && item.now_ms >= release_reg) begin
                    guard_next = 1'b0;
                end
                // expire a task whose confirmation never came
                if (task_reg != TK_NONE && deadline_hit) begin
                    task_next     = TK_NONE;
                    deadline_next = '0;
                    err_next      = (task_reg == TK_BOOT) ? E_BOOT_TO : E_UNEXPECTED;
                end
                if (intent_reg && task_next == TK_NONE) begin
                    if (seen_reg == LED_SOLID) begin
                        if (guard_open) begin
                            press         = PR_SHORT;
                            guard_next    = 1'b1;
                            release_next  = short_release;
                            task_next     = TK_AUTOREC;
                            deadline_next = new_deadline;
                            intent_next   = 1'b0;
                        end
                    end else if (seen_reg == LED_SLOW) begin
                        intent_next = 1'b0;
                    end
                end
            end
            OP_POWER_ON: begin
                if (seen_reg == LED_SOLID || seen_reg == LED_SLOW) begin
                    if (item.auto_record && seen_reg == LED_SOLID) begin
                        intent_next = 1'b1;
                    end
                end else if (task_reg != TK_NONE || !guard_open) begin
                    reply = 1'b1;
                end else begin
                    press         = PR_LONG;
                    guard_next    = 1'b1;
                    release_next  = boot_release;
                    task_next     = TK_BOOT;
                    deadline_next = new_deadline;
                    intent_next   = item.auto_record;
                    err_next      = E_NONE;
                end
            end
            OP_START_REC, OP_STOP_REC: begin
                if (seen_reg == ((item.opcode == OP_START_REC) ? LED_SLOW : LED_SOLID)) begin
                    reply = 1'b0;
                end else if (task_reg != TK_NONE || !guard_open) begin
                    reply = 1'b1;
                end else begin
                    press         = PR_SHORT;
                    guard_next    = 1'b1;
                    release_next  = short_release;
                    task_next     = (item.opcode == OP_START_REC) ? TK_START : TK_STOP;
                    deadline_next = new_deadline;
                    err_next      = E_NONE;
                end
            end
            OP_POWER_OFF: begin
                if (seen_reg == LED_OFF) begin
                    reply = 1'b0;
                end else if (task_reg != TK_NONE || !guard_open) begin
                    reply = 1'b1;
                end else begin
                    press        = PR_LONG;
                    guard_next   = 1'b1;
                    release_next = off_release;
                    intent_next  = 1'b0;
                    err_next     = E_NONE;
                end
            end
            default: begin
                reply = 1'b0;
            end
        endcase
    end

    always_comb begin
        result.reply           = reply;
        result.press_action    = press;
        result.last_error      = err_next;
        result.busy_res        = (task_next != TK_NONE) || guard_next;
        result.current_pattern = seen_next;
        result.is_recording    = (seen_next == LED_SLOW);
        result.is_idle         = (seen_next == LED_SOLID);
        result.is_off          = (seen_next == LED_OFF);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg     <= LED_UNKNOWN;
            task_reg     <= TK_NONE;
            deadline_reg <= '0;
            guard_reg    <= 1'b0;
            release_reg  <= '0;
            err_reg      <= E_NONE;
            intent_reg   <= 1'b0;
        end else if (advance) begin
            seen_reg     <= seen_next;
            task_reg     <= task_next;
            deadline_reg <= deadline_next;
            guard_reg    <= guard_next;
            release_reg  <= release_next;
            err_reg      <= err_next;
            intent_reg   <= intent_next;
        end
    end

endmodule

>>> hdl/button_led_session_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_led_session_controller
// Drives a recorder through one button and tracks its LED confirmations.
// ----------------------------------------------------------------------------
// Every accepted event (LED pattern seen, poll tick, or a power-on, start,
// stop or power-off request) yields exactly one result item carrying the
// request reply, the button action to perform and the status after the event.
// Events are taken at one per cycle unless a stalled result holds them back;
// an accepted event passes the input register, then the result register,
// before its result is offered on the m_ side. The session state is updated
// once per event; a stalled result holds back new events only once the input
// register is also full. The user must write the timing registers through the
// cfg channel only while no event is in flight; the block does not enforce
// this. Times are in milliseconds and deadlines wrap modulo 2^32.
module button_led_session_controller (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [31:0] now_ms, [34:32] led_pattern, [35] auto_record, [39:36] zero
    input  logic [blsc_pkg::S_DATA_W-1:0] s_tdata,
    // [2:0] opcode
    input  logic [blsc_pkg::OP_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] reply, [2:1] press_action, [5:3] last_error, [6] busy_res,
    // [9:7] current_pattern, [10] is_recording, [11] is_idle, [12] is_off,
    // [15:13] zero
    output logic [blsc_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [blsc_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [blsc_pkg::CDATA_W-1:0]  cfg_data
);
    import blsc_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    status_t out_res_reg;
    logic    advance;
    cfg_t    cfg;
    status_t result;

    // an item moves on when the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;

    blsc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    blsc_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.opcode      <= s_tuser;
            in_item_reg.now_ms      <= s_tdata[TIME_W-1:0];
            in_item_reg.led_pattern <= s_tdata[TIME_W+PAT_W-1:TIME_W];
            in_item_reg.auto_record <= s_tdata[TIME_W+PAT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= result;
        end
    end

    assign m_tdata = {3'b000,
                      out_res_reg.is_off,
                      out_res_reg.is_idle,
                      out_res_reg.is_recording,
                      out_res_reg.current_pattern,
                      out_res_reg.busy_res,
                      out_res_reg.last_error,
                      out_res_reg.press_action,
                      out_res_reg.reply};

    // a full input register only stalls behind a stalled result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a stalled result");

    // a wait reply never comes with a press
    a_wait_no_press: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res_reg.reply) |-> (out_res_reg.press_action == PR_NONE))
        else $error("press issued on a wait reply");

    // every press arms the guard, so the block reports busy
    a_press_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res_reg.press_action != PR_NONE) |-> out_res_reg.busy_res)
        else $error("press without busy status");

endmodule
